@@ design/cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// Holds the channel word types, the classified command word and target codes.
// ----------------------------------------------------------------------------
package cbm_pkg;

   localparam int RamBytes       = 128;
   localparam int RamAw          = 7;
   localparam int PatternSlots   = 8;
   localparam int NametableSlots = 4;
   localparam int DivSteps       = 8;

   // function codes of an input word
   localparam logic [2:0] FUNC_WRITE = 3'd0;
   localparam logic [2:0] FUNC_READ  = 3'd1;
   localparam logic [2:0] FUNC_TICK  = 3'd2;
   localparam logic [2:0] FUNC_CPU   = 3'd3;
   localparam logic [2:0] FUNC_PPU   = 3'd4;

   // register windows, address bits 15..11
   localparam logic [4:0] WIN_RAM    = 5'b01001;
   localparam logic [4:0] WIN_CNT_LO = 5'b01010;
   localparam logic [4:0] WIN_CNT_HI = 5'b01011;
   localparam logic [4:0] WIN_PRG0   = 5'b11100;
   localparam logic [4:0] WIN_PRG1   = 5'b11101;
   localparam logic [4:0] WIN_PRG2   = 5'b11110;
   localparam logic [4:0] WIN_PTR    = 5'b11111;

   // map targets
   localparam logic [2:0] TGT_PRG    = 3'd0;
   localparam logic [2:0] TGT_CHR    = 3'd1;
   localparam logic [2:0] TGT_NTRAM  = 3'd2;
   localparam logic [2:0] TGT_CHRRAM = 3'd3;
   localparam logic [2:0] TGT_NONE   = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_PRG_COUNT = 2'd0;
   localparam logic [1:0] CSR_CHR_COUNT = 2'd1;
   localparam logic [1:0] CSR_MIRROR    = 2'd2;

   localparam logic [14:0] CNT_MAX  = 15'h7FFF;
   localparam logic [7:0]  NT_PAGE0 = 8'hE0;
   localparam logic [7:0]  NT_PAGE1 = 8'hE1;

   typedef enum logic [3:0] {
      OP_NOP, OP_WR_PAT, OP_WR_NT, OP_WR_PRG0, OP_WR_PRG1, OP_WR_PRG2,
      OP_WR_PTR, OP_WR_RAM, OP_WR_CNT_LO, OP_WR_CNT_HI, OP_RD_RAM,
      OP_RD_CNT_LO, OP_RD_CNT_HI, OP_TICK, OP_CPU, OP_PPU
   } op_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [15:0] cycles;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        irq_raise;
      logic        irq_ack;
      logic [2:0]  map_target;
      logic [18:0] map_offset;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] address;
      logic [7:0]  data;
      logic [15:0] cycles;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } link_type;

endpackage

@@ design/cbm_front.sv @@
// ----------------------------------------------------------------------------
// cbm_front: input side
// Classifies each word into a command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module cbm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cbm_pkg::req_type req_data,
   output cbm_pkg::cmd_type cmd,
   input  logic             cmd_ready,
   output logic             cmd_valid
);

   cbm_pkg::cmd_type q_ff [2];
   logic             wptr_ff, rptr_ff;
   logic [1:0]       count_ff, count_in;
   cbm_pkg::op_type  op;
   logic [4:0]       win;
   logic             push, pop;

   assign win = req_data.address[15:11];

   // classify the incoming word
   always_comb begin
      op = cbm_pkg::OP_NOP;
      case (req_data.func)
         cbm_pkg::FUNC_WRITE: begin
            if (win[4:3] == 2'b10) op = cbm_pkg::OP_WR_PAT;
            else if (win[4:2] == 3'b110) op = cbm_pkg::OP_WR_NT;
            else begin
               case (win)
                  cbm_pkg::WIN_PRG0:   op = cbm_pkg::OP_WR_PRG0;
                  cbm_pkg::WIN_PRG1:   op = cbm_pkg::OP_WR_PRG1;
                  cbm_pkg::WIN_PRG2:   op = cbm_pkg::OP_WR_PRG2;
                  cbm_pkg::WIN_PTR:    op = cbm_pkg::OP_WR_PTR;
                  cbm_pkg::WIN_RAM:    op = cbm_pkg::OP_WR_RAM;
                  cbm_pkg::WIN_CNT_LO: op = cbm_pkg::OP_WR_CNT_LO;
                  cbm_pkg::WIN_CNT_HI: op = cbm_pkg::OP_WR_CNT_HI;
                  default:             op = cbm_pkg::OP_NOP;
               endcase
            end
         end
         cbm_pkg::FUNC_READ: begin
            case (win)
               cbm_pkg::WIN_RAM:    op = cbm_pkg::OP_RD_RAM;
               cbm_pkg::WIN_CNT_LO: op = cbm_pkg::OP_RD_CNT_LO;
               cbm_pkg::WIN_CNT_HI: op = cbm_pkg::OP_RD_CNT_HI;
               default:             op = cbm_pkg::OP_NOP;
            endcase
         end
         cbm_pkg::FUNC_TICK: op = cbm_pkg::OP_TICK;
         cbm_pkg::FUNC_CPU:  op = cbm_pkg::OP_CPU;
         cbm_pkg::FUNC_PPU:  op = cbm_pkg::OP_PPU;
         default:            op = cbm_pkg::OP_NOP;
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rptr_ff];
   assign push      = req_push && !req_full;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   // store the classified word
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= '{op: op, address: req_data.address,
                            data: req_data.write_data, cycles: req_data.cycles};
      end
   end

   // advance the queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop) rptr_ff <= !rptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

@@ design/cbm_divider.sv @@
// ----------------------------------------------------------------------------
// cbm_divider: bank number remainder
// Restoring remainder of an 8-bit bank by a 9-bit count, one bit a cycle.
// ----------------------------------------------------------------------------
module cbm_divider (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] dividend,
   input  logic [8:0] divisor,
   output logic       done,
   output logic [7:0] remainder
);

   logic [8:0] rem_ff, rem_in;
   logic [7:0] dq_ff;
   logic [8:0] div_ff;
   logic [3:0] steps_ff;
   logic       done_ff;
   logic [9:0] trial;

   assign trial = {rem_ff, dq_ff[7]};

   // keep the partial remainder below the divisor
   always_comb begin
      if (trial >= {1'b0, div_ff}) rem_in = 9'(trial - {1'b0, div_ff});
      else rem_in = trial[8:0];
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dq_ff  <= dividend;
         div_ff <= divisor;
      end else if (steps_ff != 4'd0) begin
         rem_ff <= rem_in;
         dq_ff  <= {dq_ff[6:0], 1'b0};
      end
   end

   // count the steps and flag the last one
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= 4'd0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (steps_ff == 4'd1);
         if (start) steps_ff <= 4'(cbm_pkg::DivSteps);
         else if (steps_ff != 4'd0) steps_ff <= steps_ff - 4'd1;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[7:0];

endmodule

@@ design/cbm_back.sv @@
// ----------------------------------------------------------------------------
// cbm_back: execution side
// Holds the bank registers, internal RAM and counter, runs each command and
// queues its result word.
// ----------------------------------------------------------------------------
module cbm_back (
   input  logic             clock,
   input  logic             reset,
   input  cbm_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [8:0]       csr_wr_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cbm_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WAIT = 3'b010,
      ST_PUSH = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [6:0]       prg_cnt_ff, prg_cnt_in;
   logic [8:0]       chr_cnt_ff, chr_cnt_in;
   logic [5:0]       prg_ff [3];
   logic [5:0]       prg_in [3];
   logic [7:0]       pat_ff [cbm_pkg::PatternSlots];
   logic [7:0]       pat_in [cbm_pkg::PatternSlots];
   logic [7:0]       nt_ff [cbm_pkg::NametableSlots];
   logic [7:0]       nt_in [cbm_pkg::NametableSlots];
   logic [1:0]       dis_ff, dis_in;
   logic [7:0]       ptr_ff, ptr_in, ptr_next;
   logic             on_ff, on_in;
   logic [14:0]      cnt_ff, cnt_in;
   cbm_pkg::rsp_type res_ff, res_in;
   logic             is_ram_ff, is_ram_in;
   logic             div_prg_ff, div_prg_in;
   logic [12:0]      low_ff, low_in;
   logic [7:0]       ram_mem [cbm_pkg::RamBytes];
   logic [cbm_pkg::RamBytes-1:0] vld_ff;
   logic [7:0]       ram_q_ff;
   logic             ram_vq_ff;
   logic             take, ram_wr, ram_rd;
   logic [6:0]       prg_eff;
   logic [13:0]      pa;
   logic [7:0]       bsel;
   logic [15:0]      cnt_gap;
   logic [15:0]      cnt_sum;
   logic             div_start, div_done;
   logic [7:0]       div_dividend, div_rem;
   logic [8:0]       div_divisor;
   cbm_pkg::rsp_type oq_ff [2];
   logic             owptr_ff, orptr_ff;
   logic [1:0]       ocount_ff;
   logic             opush, opop;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign take      = cmd_valid && cmd_ready;
   assign ram_wr    = take && (cmd.op == cbm_pkg::OP_WR_RAM);
   assign ram_rd    = take && (cmd.op == cbm_pkg::OP_RD_RAM);
   assign ptr_next  = ptr_ff[7] ? {1'b1, ptr_ff[6:0] + 7'd1} : ptr_ff;
   assign pa        = cmd.address[13:0];
   assign cnt_gap   = {1'b0, cbm_pkg::CNT_MAX - cnt_ff};
   assign cnt_sum   = {1'b0, cnt_ff} + cmd.cycles;

   // clamp the program bank count to its legal range
   always_comb begin
      if (prg_cnt_ff < 7'd2) prg_eff = 7'd2;
      else if (prg_cnt_ff > 7'd64) prg_eff = 7'd64;
      else prg_eff = prg_cnt_ff;
   end

   // run one command
   always_comb begin
      state_in     = state_ff;
      prg_cnt_in   = prg_cnt_ff;
      chr_cnt_in   = chr_cnt_ff;
      prg_in       = prg_ff;
      pat_in       = pat_ff;
      nt_in        = nt_ff;
      dis_in       = dis_ff;
      ptr_in       = ptr_ff;
      on_in        = on_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      is_ram_in    = is_ram_ff;
      div_prg_in   = div_prg_ff;
      low_in       = low_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = chr_cnt_ff;
      bsel         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_wr_en) begin
               case (csr_index)
                  cbm_pkg::CSR_PRG_COUNT: prg_cnt_in = csr_wr_data[6:0];
                  cbm_pkg::CSR_CHR_COUNT: chr_cnt_in = csr_wr_data;
                  cbm_pkg::CSR_MIRROR: begin
                     nt_in[0] = cbm_pkg::NT_PAGE0;
                     nt_in[1] = csr_wr_data[0] ? cbm_pkg::NT_PAGE1 : cbm_pkg::NT_PAGE0;
                     nt_in[2] = csr_wr_data[0] ? cbm_pkg::NT_PAGE0 : cbm_pkg::NT_PAGE1;
                     nt_in[3] = cbm_pkg::NT_PAGE1;
                  end
                  default: ;
               endcase
            end
            if (take) begin
               res_in    = '{read_data: '0, irq_raise: 1'b0, irq_ack: 1'b0,
                             map_target: cbm_pkg::TGT_NONE, map_offset: '0};
               state_in  = ST_PUSH;
               is_ram_in = 1'b0;
               case (cmd.op)
                  cbm_pkg::OP_WR_PAT:  pat_in[cmd.address[13:11]] = cmd.data;
                  cbm_pkg::OP_WR_NT:   nt_in[cmd.address[12:11]] = cmd.data;
                  cbm_pkg::OP_WR_PRG0: prg_in[0] = cmd.data[5:0];
                  cbm_pkg::OP_WR_PRG1: begin
                     prg_in[1] = cmd.data[5:0];
                     dis_in    = cmd.data[7:6];
                  end
                  cbm_pkg::OP_WR_PRG2: prg_in[2] = cmd.data[5:0];
                  cbm_pkg::OP_WR_PTR:  ptr_in = cmd.data;
                  cbm_pkg::OP_WR_RAM:  ptr_in = ptr_next;
                  cbm_pkg::OP_WR_CNT_LO: begin
                     cnt_in         = {cnt_ff[14:8], cmd.data};
                     res_in.irq_ack = 1'b1;
                  end
                  cbm_pkg::OP_WR_CNT_HI: begin
                     cnt_in         = {cmd.data[6:0], cnt_ff[7:0]};
                     on_in          = cmd.data[7];
                     res_in.irq_ack = 1'b1;
                  end
                  cbm_pkg::OP_RD_RAM: begin
                     ptr_in    = ptr_next;
                     is_ram_in = 1'b1;
                     state_in  = ST_WAIT;
                  end
                  cbm_pkg::OP_RD_CNT_LO: res_in.read_data = cnt_ff[7:0];
                  cbm_pkg::OP_RD_CNT_HI: res_in.read_data = {on_ff, cnt_ff[14:8]};
                  cbm_pkg::OP_TICK: begin
                     if (on_ff) begin
                        if (cnt_gap <= cmd.cycles) begin
                           cnt_in           = cbm_pkg::CNT_MAX;
                           on_in            = 1'b0;
                           res_in.irq_raise = 1'b1;
                        end else begin
                           cnt_in = cnt_sum[14:0];
                        end
                     end
                  end
                  cbm_pkg::OP_CPU: begin
                     if (cmd.address[15]) begin
                        res_in.map_target = cbm_pkg::TGT_PRG;
                        if (cmd.address[14:13] == 2'd3) begin
                           res_in.map_offset = {6'(prg_eff - 7'd1), cmd.address[12:0]};
                        end else begin
                           div_start    = 1'b1;
                           div_dividend = {2'b00, prg_ff[cmd.address[14:13]]};
                           div_divisor  = {2'b00, prg_eff};
                           div_prg_in   = 1'b1;
                           low_in       = cmd.address[12:0];
                           state_in     = ST_WAIT;
                        end
                     end
                  end
                  cbm_pkg::OP_PPU: begin
                     low_in     = {3'b000, pa[9:0]};
                     div_prg_in = 1'b0;
                     if (!pa[13]) begin
                        bsel = pat_ff[pa[12:10]];
                        if (bsel[7:5] == 3'b111 && !dis_ff[pa[12]]) begin
                           res_in.map_target = cbm_pkg::TGT_NTRAM;
                           res_in.map_offset = {8'd0, bsel[0], pa[9:0]};
                        end else if (chr_cnt_ff != 9'd0) begin
                           res_in.map_target = cbm_pkg::TGT_CHR;
                           div_start         = 1'b1;
                           div_dividend      = bsel;
                           state_in          = ST_WAIT;
                        end else begin
                           res_in.map_target = cbm_pkg::TGT_CHRRAM;
                           res_in.map_offset = {6'd0, pa[12:0]};
                        end
                     end else if (pa[13:8] != 6'h3F) begin
                        bsel = nt_ff[pa[11:10]];
                        if (bsel[7:5] == 3'b111 || chr_cnt_ff == 9'd0) begin
                           res_in.map_target = cbm_pkg::TGT_NTRAM;
                           res_in.map_offset = {8'd0, bsel[0], pa[9:0]};
                        end else begin
                           res_in.map_target = cbm_pkg::TGT_CHR;
                           div_start         = 1'b1;
                           div_dividend      = bsel;
                           state_in          = ST_WAIT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WAIT: begin
            if (is_ram_ff) begin
               res_in.read_data = ram_vq_ff ? ram_q_ff : 8'd0;
               state_in         = ST_PUSH;
            end else if (div_done) begin
               if (div_prg_ff) res_in.map_offset = {div_rem[5:0], low_ff};
               else res_in.map_offset = {1'b0, div_rem, low_ff[9:0]};
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (ocount_ff != 2'd2) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   cbm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   // internal RAM, registered read
   always_ff @(posedge clock) begin
      if (ram_wr) ram_mem[ptr_ff[6:0]] <= cmd.data;
      if (ram_rd) ram_q_ff <= ram_mem[ptr_ff[6:0]];
   end

   // mark written RAM bytes; unwritten ones read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         ram_vq_ff <= 1'b0;
      end else begin
         if (ram_wr) vld_ff[ptr_ff[6:0]] <= 1'b1;
         if (ram_rd) ram_vq_ff <= vld_ff[ptr_ff[6:0]];
      end
   end

   always_ff @(posedge clock) begin
      res_ff     <= res_in;
      div_prg_ff <= div_prg_in;
      low_ff     <= low_in;
   end

   // hold the mapper state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         prg_cnt_ff <= 7'd2;
         chr_cnt_ff <= 9'd0;
         prg_ff     <= '{6'd0, 6'd1, 6'd2};
         for (int i = 0; i < cbm_pkg::PatternSlots; i++) pat_ff[i] <= 8'(i);
         nt_ff      <= '{cbm_pkg::NT_PAGE0, cbm_pkg::NT_PAGE0,
                         cbm_pkg::NT_PAGE1, cbm_pkg::NT_PAGE1};
         dis_ff     <= 2'd0;
         ptr_ff     <= 8'd0;
         on_ff      <= 1'b0;
         cnt_ff     <= 15'd0;
         is_ram_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         prg_cnt_ff <= prg_cnt_in;
         chr_cnt_ff <= chr_cnt_in;
         prg_ff     <= prg_in;
         pat_ff     <= pat_in;
         nt_ff      <= nt_in;
         dis_ff     <= dis_in;
         ptr_ff     <= ptr_in;
         on_ff      <= on_in;
         cnt_ff     <= cnt_in;
         is_ram_ff  <= is_ram_in;
      end
   end

   // result queue
   assign opush     = (state_ff == ST_PUSH) && (ocount_ff != 2'd2);
   assign rsp_empty = (ocount_ff == 2'd0);
   assign opop      = rsp_pop && !rsp_empty;
   assign rsp_data  = oq_ff[orptr_ff];

   always_ff @(posedge clock) begin
      if (opush) oq_ff[owptr_ff] <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owptr_ff  <= 1'b0;
         orptr_ff  <= 1'b0;
         ocount_ff <= 2'd0;
      end else begin
         if (opush) owptr_ff <= !owptr_ff;
         if (opop) orptr_ff <= !orptr_ff;
         if (opush && !opop) ocount_ff <= ocount_ff + 2'd1;
         else if (opop && !opush) ocount_ff <= ocount_ff - 2'd1;
      end
   end

endmodule

@@ design/cartridge_bank_mapper_with_irq_unit.sv @@
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_unit: bank mapper with interrupt counter
// Front classifies words into a queue, back executes them against the banks.
//
//   channel | ports                         | direction
//   req     | req_push req_full req_data    | in, one word per access
//   rsp     | rsp_empty rsp_pop rsp_data    | out, one word per request word
//   csr     | csr_wr_en csr_index csr_wr_data | in, write only
//
// In the back each word passes the idle and push states; RAM reads add a wait
// state (registered RAM port), bank maps wrapping modulo the bank count wait on
// the bit-serial remainder unit. Reset: synchronous; RAM needs no clearing pass.
// Stalls: two words queue on each side; the back waits on a full result queue.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cbm_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cbm_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [8:0]       csr_wr_data
);

   cbm_pkg::cmd_type cmd;
   cbm_pkg::link_type link;

   cbm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd       (cmd),
      .cmd_ready (link.ready),
      .cmd_valid (link.valid)
   );

   cbm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cmd_valid   (link.valid),
      .cmd_ready   (link.ready),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");
   a_raise_ack : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_data.irq_raise && rsp_data.irq_ack))
      else $error("raise and acknowledge in one word");
   a_none_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.map_target == cbm_pkg::TGT_NONE) |->
      (rsp_data.map_offset == 19'd0))
      else $error("unmapped word carries an offset");
`endif

endmodule

@@ tb/sv/cartridge_bank_mapper_with_irq_unit_tb.sv @@
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_unit_tb: self-checking bench of the mapper
// Walks a short table of directed words, then random phases under several
// register settings. Each response word is compared with a predicted word.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomWords = 950;
   localparam int DrainCycles = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   cbm_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   cbm_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [8:0]       csr_wr_data = '0;

   // mapper state mirrored by the bench
   logic [6:0]  m_prg_count;
   logic [8:0]  m_chr_count;
   logic        m_vertical;
   logic [5:0]  m_prg_bank [3];
   logic [7:0]  m_pat_bank [cbm_pkg::PatternSlots];
   logic [7:0]  m_nt_bank [cbm_pkg::NametableSlots];
   logic [1:0]  m_nt_disable;
   logic [7:0]  m_pointer;
   logic [7:0]  m_ram [cbm_pkg::RamBytes];
   logic        m_irq_on;
   logic [14:0] m_count;

   cbm_pkg::rsp_type pending_words [$];
   int          mismatches = 0;
   bit          hold_off = 1'b0;
   bit          stall_mode = 1'b0;

   cartridge_bank_mapper_with_irq_unit u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void load_nt_pattern();
      m_nt_bank[0] = cbm_pkg::NT_PAGE0;
      m_nt_bank[1] = m_vertical ? cbm_pkg::NT_PAGE1 : cbm_pkg::NT_PAGE0;
      m_nt_bank[2] = m_vertical ? cbm_pkg::NT_PAGE0 : cbm_pkg::NT_PAGE1;
      m_nt_bank[3] = cbm_pkg::NT_PAGE1;
   endfunction

   function automatic void mapper_reset();
      m_prg_count = 7'd2;
      m_chr_count = '0;
      m_vertical  = 1'b0;
      for (int i = 0; i < 3; i++) m_prg_bank[i] = 6'(i);
      for (int i = 0; i < cbm_pkg::PatternSlots; i++) m_pat_bank[i] = 8'(i);
      load_nt_pattern();
      m_nt_disable = '0;
      m_pointer = '0;
      for (int i = 0; i < cbm_pkg::RamBytes; i++) m_ram[i] = '0;
      m_irq_on = 1'b0;
      m_count = '0;
   endfunction

   // internal RAM access through the pointer, with optional auto-increment
   function automatic logic [7:0] ram_touch(bit wr, logic [7:0] d);
      logic [6:0] idx;
      idx = m_pointer[6:0];
      if (wr) m_ram[idx] = d;
      if (m_pointer[7]) m_pointer = {1'b1, 7'(m_pointer[6:0] + 7'd1)};
      return m_ram[idx];
   endfunction

   function automatic cbm_pkg::rsp_type mapper_step(cbm_pkg::req_type rq);
      cbm_pkg::rsp_type o;
      logic [4:0]  win;
      int unsigned cnt, bank, slot;
      logic [13:0] pa;
      logic [7:0]  b;
      o = '0;
      o.map_target = cbm_pkg::TGT_NONE;
      win = rq.address[15:11];
      case (rq.func)
         cbm_pkg::FUNC_WRITE: begin
            if (win >= 5'b10000 && win <= 5'b10111) begin
               m_pat_bank[win[2:0]] = rq.write_data;
            end else if (win >= 5'b11000 && win <= 5'b11011) begin
               m_nt_bank[win[1:0]] = rq.write_data;
            end else if (win == cbm_pkg::WIN_PRG0) begin
               m_prg_bank[0] = rq.write_data[5:0];
            end else if (win == cbm_pkg::WIN_PRG1) begin
               m_prg_bank[1] = rq.write_data[5:0];
               m_nt_disable = rq.write_data[7:6];
            end else if (win == cbm_pkg::WIN_PRG2) begin
               m_prg_bank[2] = rq.write_data[5:0];
            end else if (win == cbm_pkg::WIN_PTR) begin
               m_pointer = rq.write_data;
            end else if (win == cbm_pkg::WIN_RAM) begin
               void'(ram_touch(1'b1, rq.write_data));
            end else if (win == cbm_pkg::WIN_CNT_LO) begin
               m_count[7:0] = rq.write_data;
               o.irq_ack = 1'b1;
            end else if (win == cbm_pkg::WIN_CNT_HI) begin
               m_count[14:8] = rq.write_data[6:0];
               m_irq_on = rq.write_data[7];
               o.irq_ack = 1'b1;
            end
         end
         cbm_pkg::FUNC_READ: begin
            if (win == cbm_pkg::WIN_RAM) o.read_data = ram_touch(1'b0, '0);
            else if (win == cbm_pkg::WIN_CNT_LO) o.read_data = m_count[7:0];
            else if (win == cbm_pkg::WIN_CNT_HI) o.read_data = {m_irq_on, m_count[14:8]};
         end
         cbm_pkg::FUNC_TICK: begin
            if (m_irq_on) begin
               if (int'(cbm_pkg::CNT_MAX) - int'(m_count) <= int'(rq.cycles)) begin
                  m_count = cbm_pkg::CNT_MAX;
                  m_irq_on = 1'b0;
                  o.irq_raise = 1'b1;
               end else begin
                  m_count = 15'(m_count + rq.cycles);
               end
            end
         end
         cbm_pkg::FUNC_CPU: begin
            if (rq.address[15]) begin
               cnt = m_prg_count;
               if (cnt < 2) cnt = 2;
               if (cnt > 64) cnt = 64;
               slot = rq.address[14:13];
               bank = (slot == 3) ? cnt - 1 : m_prg_bank[slot] % cnt;
               o.map_target = cbm_pkg::TGT_PRG;
               o.map_offset = 19'(bank * 8192 + rq.address[12:0]);
            end
         end
         cbm_pkg::FUNC_PPU: begin
            pa = rq.address[13:0];
            if (pa < 14'h2000) begin
               b = m_pat_bank[pa[12:10]];
               if (b >= cbm_pkg::NT_PAGE0 && !m_nt_disable[pa[12]]) begin
                  o.map_target = cbm_pkg::TGT_NTRAM;
                  o.map_offset = 19'({b[0], pa[9:0]});
               end else if (m_chr_count != 0) begin
                  o.map_target = cbm_pkg::TGT_CHR;
                  o.map_offset = 19'((b % m_chr_count) * 1024 + pa[9:0]);
               end else begin
                  o.map_target = cbm_pkg::TGT_CHRRAM;
                  o.map_offset = 19'(pa[12:0]);
               end
            end else if (pa < 14'h3F00) begin
               b = m_nt_bank[pa[11:10]];
               if (b >= cbm_pkg::NT_PAGE0 || m_chr_count == 0) begin
                  o.map_target = cbm_pkg::TGT_NTRAM;
                  o.map_offset = 19'({b[0], pa[9:0]});
               end else begin
                  o.map_target = cbm_pkg::TGT_CHR;
                  o.map_offset = 19'((b % m_chr_count) * 1024 + pa[9:0]);
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // offer one word, predict its response on acceptance
   task automatic send_word(cbm_pkg::req_type rq);
      req_push <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (req_full);
      pending_words.push_back(mapper_step(rq));
   endtask

   task automatic send_gapped(cbm_pkg::req_type rq);
      int g;
      send_word(rq);
      g = stall_mode ? 0 : gap_len();
      if (g > 0) begin
         req_push <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [8:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == cbm_pkg::CSR_PRG_COUNT) m_prg_count = val[6:0];
      else if (idx == cbm_pkg::CSR_CHR_COUNT) m_chr_count = val;
      else begin
         m_vertical = val[0];
         load_nt_pattern();
      end
   endtask

   function automatic cbm_pkg::req_type mk(logic [2:0] f, logic [15:0] a, logic [7:0] d,
                                           logic [15:0] c);
      cbm_pkg::req_type r;
      r.func = f; r.address = a; r.write_data = d; r.cycles = c;
      return r;
   endfunction

   // random word: mostly bank writes and maps, some counter and RAM traffic
   function automatic cbm_pkg::req_type random_word();
      cbm_pkg::req_type r;
      int k;
      r = mk(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom), 16'($urandom));
      k = $urandom_range(0, 99);
      if (k < 30) begin
         r.func = cbm_pkg::FUNC_WRITE;
         r.address[15:11] = 5'($urandom_range(5'b10000, 5'b11111));
         if ($urandom_range(0, 2) == 0) r.write_data[7:5] = 3'b111;
      end else if (k < 42) begin
         r.func = $urandom_range(0, 1) ? cbm_pkg::FUNC_WRITE : cbm_pkg::FUNC_READ;
         r.address[15:11] = 5'($urandom_range(cbm_pkg::WIN_RAM, cbm_pkg::WIN_CNT_HI));
      end else if (k < 55) begin
         r.func = cbm_pkg::FUNC_TICK;
         if ($urandom_range(0, 3) != 0) r.cycles = 16'($urandom_range(0, 2000));
      end else if (k < 72) begin
         r.func = cbm_pkg::FUNC_CPU;
      end else if (k < 95) begin
         r.func = cbm_pkg::FUNC_PPU;
      end
      return r;
   endfunction

   // response side: check each word against the oldest prediction
   always @(posedge clock) begin
      cbm_pkg::rsp_type exp_word;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_data);
         end else begin
            exp_word = pending_words.pop_front();
            if (rsp_data.read_data !== exp_word.read_data ||
                rsp_data.irq_raise !== exp_word.irq_raise ||
                rsp_data.irq_ack !== exp_word.irq_ack ||
                rsp_data.map_target !== exp_word.map_target ||
                rsp_data.map_offset !== exp_word.map_offset) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch: expected %h actual %h", exp_word, rsp_data);
            end
         end
      end
   end

   // pop with random gaps, held low during a long hold-off
   initial begin
      int g;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_pop <= 1'b0;
            @(posedge clock);
         end else begin
            g = gap_len();
            rsp_pop <= (g == 0);
            @(posedge clock);
            if (g > 0) begin
               repeat (g - 1) @(posedge clock);
               rsp_pop <= 1'b1;
               @(posedge clock);
            end
         end
      end
   end

   typedef struct {
      cbm_pkg::req_type rq;
      bit               known;
      cbm_pkg::rsp_type rs;
   } row_type;

   initial begin
      row_type rows [$];
      cbm_pkg::rsp_type none, z;
      logic [8:0] chr_set [4] = '{9'd0, 9'd1, 9'd256, 9'd511};
      logic [6:0] prg_set [4] = '{7'd2, 7'd64, 7'd0, 7'd127};
      int n;
      none = '0; none.map_target = cbm_pkg::TGT_NONE;
      mapper_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      z = none; z.map_target = cbm_pkg::TGT_PRG; z.map_offset = 19'd0;
      rows.push_back('{mk(cbm_pkg::FUNC_CPU, 16'h8000, 0, 0), 1, z});
      z.map_offset = 19'(8192 + 16'h1FFF);
      rows.push_back('{mk(cbm_pkg::FUNC_CPU, 16'hFFFF, 0, 0), 1, z});
      rows.push_back('{mk(cbm_pkg::FUNC_CPU, 16'h7FFF, 0, 0), 1, none});
      rows.push_back('{mk(cbm_pkg::FUNC_READ, 16'h5800, 0, 0), 1, none});
      rows.push_back('{mk(cbm_pkg::FUNC_PPU, 16'h3F00, 0, 0), 1, none});
      rows.push_back('{mk(3'd7, 16'hFFFF, 8'hFF, 16'hFFFF), 1, none});
      rows.push_back('{mk(3'd5, 16'h4800, 8'h12, 16'h0001), 1, none});
      z = none; z.irq_ack = 1'b1;
      rows.push_back('{mk(cbm_pkg::FUNC_WRITE, 16'h5000, 8'hF0, 0), 1, z});
      rows.push_back('{mk(cbm_pkg::FUNC_WRITE, 16'h5FFF, 8'hFF, 0), 1, z});
      rows.push_back('{mk(cbm_pkg::FUNC_TICK, 0, 0, 16'h000F), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_TICK, 0, 0, 16'hFFFF), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_READ, 16'h5000, 0, 0), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_WRITE, 16'hF800, 8'hFE, 0), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_WRITE, 16'h4800, 8'hA5, 0), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_WRITE, 16'h4800, 8'h5A, 0), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_WRITE, 16'hF800, 8'h7F, 0), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_READ, 16'h4800, 0, 0), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_WRITE, 16'h8000, 8'hE1, 0), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_WRITE, 16'hE800, 8'hFF, 0), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_PPU, 16'h0123, 0, 0), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_PPU, 16'hEFFF, 0, 0), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_WRITE, 16'hD800, 8'h05, 0), 0, none});
      rows.push_back('{mk(cbm_pkg::FUNC_PPU, 16'h2C00, 0, 0), 0, none});
      foreach (rows[i]) begin
         if (rows[i].known) begin
            send_word(rows[i].rq);
            pending_words[$] = rows[i].rs;
         end else begin
            send_word(rows[i].rq);
         end
      end
      drain();

      // random phases over register settings
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(cbm_pkg::CSR_PRG_COUNT,
                   ph < 4 ? 9'(prg_set[ph]) : 9'($urandom_range(0, 127)));
         csr_write(cbm_pkg::CSR_CHR_COUNT,
                   ph < 4 ? chr_set[ph] : 9'($urandom_range(0, 300)));
         csr_write(cbm_pkg::CSR_MIRROR, 9'(ph & 1));
         n = RandomWords / 8;
         if (ph == 2) begin
            // long receiver hold-off with the sender pushing flat out
            stall_mode = 1'b1;
            hold_off = 1'b1;
            fork
               begin
                  repeat (60) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int i = 0; i < n; i++) begin
            if (i == 40) stall_mode = 1'b0;
            send_gapped(random_word());
            if (i == n / 2) begin
               // sender pause until every prediction is met
               req_push <= 1'b0;
               while (pending_words.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
